// File: hw/rtl/gaussian_score_point_classifier_unit_macros.svh
// Assertion helpers for the point classifier.
`ifndef GAUSSIAN_SCORE_POINT_CLASSIFIER_UNIT_MACROS_SVH
`define GAUSSIAN_SCORE_POINT_CLASSIFIER_UNIT_MACROS_SVH

// Checked only out of reset.
`define GSCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GSCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/gscl_pkg.sv
package gscl_pkg;

  // Register indexes on the config port.
  typedef enum logic [2:0] {
    CFG_OBSERV_MEAN     = 3'd0,
    CFG_OBSERV_STDEV    = 3'd1,
    CFG_ERROR_MEAN      = 3'd2,
    CFG_ERROR_STDEV     = 3'd3,
    CFG_DEPTH_MEAN      = 3'd4,
    CFG_DEPTH_STDEV     = 3'd5,
    CFG_SCORE_THRESHOLD = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] RST_MEAN      = 16'd0;
  localparam logic [15:0] RST_STDEV     = 16'd256;
  localparam logic [17:0] RST_THRESHOLD = 18'd98304;

  // Quotient bits kept; anything at or above 2^QBITS is past the cutoff anyway.
  localparam int QBITS     = 20;
  localparam int EXP_STEPS = 16;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [19:0] K_LIMIT   = 20'd786432;   // 12.0 in Q16.16
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // Pipeline stage positions.
  localparam int ST_DIST  = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_DIV0  = 2;
  localparam int ST_Y     = ST_DIV0 + QBITS;
  localparam int ST_EXP0  = ST_Y + 1;
  localparam int ST_SCORE = ST_EXP0 + EXP_STEPS;
  localparam int ST_OUT   = ST_SCORE + 1;
  localparam int NSTG     = ST_OUT + 1;

  typedef logic [NSTG-1:0] stage_en_t;

  typedef struct packed {
    logic [47:0]      rem;
    logic [QBITS-1:0] quo;
    logic             ov;
  } div_stage_t;

  typedef struct packed {
    logic [30:0] acc;
    logic [15:0] frac;
    logic [4:0]  n;
    logic        zero;
  } exp_stage_t;

  // Bitwise integer square root, elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q2.30, built by repeated square roots from one half.
  function automatic logic [63:0] exp_tap(input int i);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int j = 1; j <= i; j++) begin
      t = isqrt64(t << 30);
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/gscl_ifs.sv
interface gscl_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  observ_count;
  logic [15:0] mean_error;
  logic [15:0] mean_depth;
  modport source(output valid, observ_count, mean_error, mean_depth, input ready);
  modport sink(input valid, observ_count, mean_error, mean_depth, output ready);
endinterface

interface gscl_out_if;
  logic valid;
  logic ready;
  logic is_static;
  modport source(output valid, is_static, input ready);
  modport sink(input valid, is_static, output ready);
endinterface

// File: hw/rtl/gscl_div.sv
// |x-mean|, squared, then a restoring divide by 2*stdev^2, one quotient bit a stage.
module gscl_div (
  input  logic                      clk,
  input  gscl_pkg::stage_en_t       en,
  input  logic [15:0]               x,
  input  logic [15:0]               mean,
  input  logic [15:0]               stdev,
  output logic [gscl_pkg::QBITS-1:0] kq,
  output logic                      ov
);

  logic [15:0] d_r;
  logic [31:0] sq_r;
  logic [32:0] den_r;
  logic [15:0] s_eff;
  gscl_pkg::div_stage_t div_r [gscl_pkg::QBITS];

  assign s_eff = (stdev == 16'd0) ? 16'd1 : stdev;

  always_ff @(posedge clk) begin
    den_r <= {32'(s_eff) * 32'(s_eff), 1'b0};
    if (en[gscl_pkg::ST_DIST]) begin
      d_r <= (x >= mean) ? (x - mean) : (mean - x);
    end
    if (en[gscl_pkg::ST_SQ]) begin
      sq_r <= 32'(d_r) * 32'(d_r);
    end
  end

  for (genvar j = 0; j < gscl_pkg::QBITS; j++) begin : g_div
    localparam int B = gscl_pkg::QBITS - 1 - j;
    gscl_pkg::div_stage_t src;
    logic [52:0] sub;
    logic        ge;

    if (j == 0) begin : g_first
      assign src.rem = {sq_r, 16'd0};
      assign src.quo = '0;
      assign src.ov  = 37'(sq_r) >= (37'(den_r) << 4);
    end else begin : g_next
      assign src = div_r[j-1];
    end

    assign sub = 53'(den_r) << B;
    assign ge  = 53'(src.rem) >= sub;

    always_ff @(posedge clk) begin
      if (en[gscl_pkg::ST_DIV0 + j]) begin
        div_r[j].rem <= ge ? 48'(53'(src.rem) - sub) : src.rem;
        div_r[j].quo <= {src.quo[gscl_pkg::QBITS-2:0], ge};
        div_r[j].ov  <= src.ov;
      end
    end
  end

  assign kq = div_r[gscl_pkg::QBITS-1].quo;
  assign ov = div_r[gscl_pkg::QBITS-1].ov;

endmodule

// File: hw/rtl/gscl_exp.sv
// k -> exp(-k) in Q0.16: scale by log2(e), walk the fraction bits, round-shift by the integer part.
module gscl_exp (
  input  logic                       clk,
  input  gscl_pkg::stage_en_t        en,
  input  logic [gscl_pkg::QBITS-1:0] kq,
  input  logic                       ov,
  output logic [15:0]                score
);

  gscl_pkg::exp_stage_t y_r;
  gscl_pkg::exp_stage_t ex_r [gscl_pkg::EXP_STEPS];
  logic [36:0] prod;
  logic [15:0] score_r;

  assign prod = 37'(kq) * 37'(gscl_pkg::LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (en[gscl_pkg::ST_Y]) begin
      y_r.acc  <= gscl_pkg::ONE_Q30;
      y_r.frac <= prod[31:16];
      y_r.n    <= prod[36:32];
      y_r.zero <= ov || (kq >= gscl_pkg::K_LIMIT);
    end
  end

  for (genvar i = 1; i <= gscl_pkg::EXP_STEPS; i++) begin : g_exp
    localparam logic [30:0] TAP = 31'(gscl_pkg::exp_tap(i));
    gscl_pkg::exp_stage_t src;
    gscl_pkg::exp_stage_t stg_nxt;
    logic [61:0] mul;

    if (i == 1) begin : g_first
      assign src = y_r;
    end else begin : g_next
      assign src = ex_r[i-2];
    end

    assign mul = 62'(src.acc) * 62'(TAP);

    always_comb begin
      stg_nxt = src;
      if (src.frac[gscl_pkg::EXP_STEPS - i]) begin
        stg_nxt.acc = mul[60:30];
      end
    end

    always_ff @(posedge clk) begin
      if (en[gscl_pkg::ST_EXP0 + i - 1]) begin
        ex_r[i-1] <= stg_nxt;
      end
    end
  end

  gscl_pkg::exp_stage_t last;
  logic [47:0] rnd;
  logic [47:0] shifted;

  assign last    = ex_r[gscl_pkg::EXP_STEPS-1];
  assign rnd     = 48'(last.acc) + (48'd1 << (6'(last.n) + 6'd13));
  assign shifted = rnd >> (6'(last.n) + 6'd14);

  always_ff @(posedge clk) begin
    if (en[gscl_pkg::ST_SCORE]) begin
      if (last.zero) begin
        score_r <= 16'd0;
      end else if (shifted > 48'd65535) begin
        score_r <= 16'hFFFF;
      end else begin
        score_r <= shifted[15:0];
      end
    end
  end

  assign score = score_r;

endmodule

// File: hw/rtl/gaussian_score_point_classifier_unit.sv
// Gaussian score point classifier.
// in_ch carries one map point per item (observ_count, mean_error, mean_depth);
// out_ch returns one is_static bit per point, in order. Both are valid/ready.
// cfg_we/cfg_index/cfg_wdata write the means, stdevs and threshold; write only
// while no point is in flight. Unknown indexes are dropped.
// Throughput: one point per cycle while out_ch takes results. Each feature runs
// |x-mean|, a square, a 20-stage one-bit-per-stage divide, a log2(e) scale,
// 16 exp multiply stages and a round; then the three scores are summed and
// compared. The pipe has 41 register stages in all.
// Each stage has its own valid bit and moves when its successor has room, so
// bubbles close up and in_ch keeps taking items while the result register
// waits on a stalled receiver until the whole pipe is full.
// Reset (rst_n low, synchronous) empties the pipe and loads the default
// config: means 0, stdevs 1.0, threshold 1.5. No clearing pass is needed.
module gaussian_score_point_classifier_unit (
  input  logic              clk,
  input  logic              rst_n,
  gscl_in_if.sink           in_ch,
  gscl_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [17:0]       cfg_wdata
);

  `include "gaussian_score_point_classifier_unit_macros.svh"

  localparam int LAST = gscl_pkg::NSTG - 1;

  // config registers
  logic [15:0] observ_mean_r, observ_stdev_r;
  logic [15:0] error_mean_r, error_stdev_r;
  logic [15:0] depth_mean_r, depth_stdev_r;
  logic [17:0] score_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      observ_mean_r     <= gscl_pkg::RST_MEAN;
      observ_stdev_r    <= gscl_pkg::RST_STDEV;
      error_mean_r      <= gscl_pkg::RST_MEAN;
      error_stdev_r     <= gscl_pkg::RST_STDEV;
      depth_mean_r      <= gscl_pkg::RST_MEAN;
      depth_stdev_r     <= gscl_pkg::RST_STDEV;
      score_threshold_r <= gscl_pkg::RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        gscl_pkg::CFG_OBSERV_MEAN:     observ_mean_r     <= cfg_wdata[15:0];
        gscl_pkg::CFG_OBSERV_STDEV:    observ_stdev_r    <= cfg_wdata[15:0];
        gscl_pkg::CFG_ERROR_MEAN:      error_mean_r      <= cfg_wdata[15:0];
        gscl_pkg::CFG_ERROR_STDEV:     error_stdev_r     <= cfg_wdata[15:0];
        gscl_pkg::CFG_DEPTH_MEAN:      depth_mean_r      <= cfg_wdata[15:0];
        gscl_pkg::CFG_DEPTH_STDEV:     depth_stdev_r     <= cfg_wdata[15:0];
        gscl_pkg::CFG_SCORE_THRESHOLD: score_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  gscl_pkg::stage_en_t v_r;
  gscl_pkg::stage_en_t en;
  logic in_fire;

  always_comb begin
    en[LAST] = !v_r[LAST] || out_ch.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // three feature lanes
  logic [15:0] cnt_q88;
  logic [gscl_pkg::QBITS-1:0] kq_o, kq_e, kq_d;
  logic ov_o, ov_e, ov_d;
  logic [15:0] sc_o, sc_e, sc_d;

  assign cnt_q88 = {in_ch.observ_count, 8'd0};

  gscl_div u_div_o (.clk, .en, .x(cnt_q88), .mean(observ_mean_r),
                    .stdev(observ_stdev_r), .kq(kq_o), .ov(ov_o));
  gscl_div u_div_e (.clk, .en, .x(in_ch.mean_error), .mean(error_mean_r),
                    .stdev(error_stdev_r), .kq(kq_e), .ov(ov_e));
  gscl_div u_div_d (.clk, .en, .x(in_ch.mean_depth), .mean(depth_mean_r),
                    .stdev(depth_stdev_r), .kq(kq_d), .ov(ov_d));

  gscl_exp u_exp_o (.clk, .en, .kq(kq_o), .ov(ov_o), .score(sc_o));
  gscl_exp u_exp_e (.clk, .en, .kq(kq_e), .ov(ov_e), .score(sc_e));
  gscl_exp u_exp_d (.clk, .en, .kq(kq_d), .ov(ov_d), .score(sc_d));

  // sum and threshold into the result register
  logic [17:0] sum;
  logic        is_static_r;

  assign sum = 18'(sc_o) + 18'(sc_e) + 18'(sc_d);

  always_ff @(posedge clk) begin
    if (en[gscl_pkg::ST_OUT]) begin
      is_static_r <= sum > score_threshold_r;
    end
  end

  assign out_ch.valid     = v_r[LAST];
  assign out_ch.is_static = is_static_r;

  `GSCL_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_ch.valid, "result valid right after reset")
  `GSCL_ASSERT(a_ready_when_drained, !out_ch.valid |-> in_ch.ready, "input stalled with empty output")
  `GSCL_ASSERT(a_accept_lands, in_fire |=> v_r[0], "accepted item missing from first stage")

endmodule

// File: tb/sv/tb_gaussian_score_point_classifier_unit.sv
`timescale 1ns / 100ps

module tb_gaussian_score_point_classifier_unit;

  // Write to this index must be dropped by the block.
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;
  localparam logic [63:0] LOG2E_FIX = 64'd94548;   // log2(e) in Q16.16
  localparam logic [63:0] K_CUTOFF  = 64'd12 << 16; // exponent at which score is 0
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;              // a bit past the 41-stage pipe

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [17:0] cfg_wdata;

  gscl_in_if  in_ch ();
  gscl_out_if out_ch ();

  gaussian_score_point_classifier_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's registers; index 0 observ, 1 error, 2 depth.
  logic [15:0] feat_mean [3];
  logic [15:0] feat_sdev [3];
  logic [17:0] static_thresh;

  // 2^(-2^-i) in Q2.30, one tap per fraction bit of the exponent.
  logic [63:0] half_root_tap [17];

  logic expected_static_q[$];
  int   fail_count;
  int   idle_cycles;
  int   send_gap_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << 32;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // exp(-(x-mean)^2 / (2 sd^2)) in Q0.16, done as 2^-(k*log2e).
  function automatic logic [15:0] gauss_weight(input logic [15:0] x, input logic [15:0] mean,
                                               input logic [15:0] sd);
    logic [63:0] delta;
    logic [63:0] sdev;
    logic [63:0] kq;
    logic [63:0] y;
    logic [63:0] acc;
    logic [63:0] rnd;
    int unsigned n;
    delta = (x >= mean) ? 64'(x - mean) : 64'(mean - x);
    sdev = (sd == 16'd0) ? 64'd1 : 64'(sd);   // zero stdev acts as 1/256
    kq = ((delta * delta) << 16) / (2 * sdev * sdev);
    if (kq >= K_CUTOFF) return 16'd0;
    y = (kq * LOG2E_FIX) >> 16;
    n = 32'(y >> 16);
    acc = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (y[16-i]) acc = (acc * half_root_tap[i]) >> 30;
    end
    rnd = (acc + (64'd1 << (13 + n))) >> (14 + n);
    return (rnd > 64'd65535) ? 16'hFFFF : rnd[15:0];
  endfunction

  function automatic logic classify_point(input logic [7:0] cnt, input logic [15:0] err,
                                          input logic [15:0] dep);
    logic [17:0] total;
    total = 18'(gauss_weight({cnt, 8'd0}, feat_mean[0], feat_sdev[0]))
          + 18'(gauss_weight(err, feat_mean[1], feat_sdev[1]))
          + 18'(gauss_weight(dep, feat_mean[2], feat_sdev[2]));
    return total > static_thresh;
  endfunction

  // Register write; the block must be idle.
  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gscl_pkg::CFG_OBSERV_MEAN:     feat_mean[0] = val[15:0];
      gscl_pkg::CFG_OBSERV_STDEV:    feat_sdev[0] = val[15:0];
      gscl_pkg::CFG_ERROR_MEAN:      feat_mean[1] = val[15:0];
      gscl_pkg::CFG_ERROR_STDEV:     feat_sdev[1] = val[15:0];
      gscl_pkg::CFG_DEPTH_MEAN:      feat_mean[2] = val[15:0];
      gscl_pkg::CFG_DEPTH_STDEV:     feat_sdev[2] = val[15:0];
      gscl_pkg::CFG_SCORE_THRESHOLD: static_thresh = val;
      default: ;
    endcase
  endtask

  // Sends one item after an optional random gap; valid is left high so back-to-back items stay high.
  task automatic send_point(input logic [7:0] cnt, input logic [15:0] err,
                            input logic [15:0] dep);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.observ_count <= cnt;
    in_ch.mean_error   <= err;
    in_ch.mean_depth   <= dep;
    do @(posedge clk); while (!in_ch.ready);
    expected_static_q.insert(expected_static_q.size(), classify_point(cnt, err, dep));
  endtask

  // Drop valid, wait for every result, then let the pipe settle.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_static_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] om, input logic [15:0] os, input logic [15:0] em,
                           input logic [15:0] es, input logic [15:0] dm, input logic [15:0] ds,
                           input logic [17:0] th);
    write_reg(gscl_pkg::CFG_OBSERV_MEAN, 18'(om));
    write_reg(gscl_pkg::CFG_OBSERV_STDEV, 18'(os));
    write_reg(gscl_pkg::CFG_ERROR_MEAN, 18'(em));
    write_reg(gscl_pkg::CFG_ERROR_STDEV, 18'(es));
    write_reg(gscl_pkg::CFG_DEPTH_MEAN, 18'(dm));
    write_reg(gscl_pkg::CFG_DEPTH_STDEV, 18'(ds));
    write_reg(gscl_pkg::CFG_SCORE_THRESHOLD, th);
  endtask

  // Defaults out of reset: field extremes, exact means, far points.
  task automatic test_reset_defaults();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    send_point(8'd0, 16'd0, 16'd0);          // all at mean, saturated scores
    send_point(8'd255, 16'hFFFF, 16'hFFFF);  // all far away
    send_point(8'd0, 16'hFFFF, 16'd0);
    send_point(8'd1, 16'd256, 16'd0);        // one stdev off
    send_point(8'd0, 16'd128, 16'd384);
    send_point(8'd2, 16'd0, 16'd1);
    send_point(8'd255, 16'd0, 16'd0);
    drain_results();
  endtask

  // Zero stdev, oversized values, dropped index, threshold extremes.
  task automatic test_register_corners();
    write_all(16'd512, 16'd0, 16'd1000, 16'd0, 16'd0, 16'd0, 18'd0);
    send_point(8'd2, 16'd1000, 16'd0);       // exact hits with zero stdev
    send_point(8'd2, 16'd1001, 16'd1);       // one lsb off: k is 0.5, short of cutoff
    send_point(8'd3, 16'd999, 16'd0);
    drain_results();
    // Upper bits of 16-bit registers are dropped.
    write_reg(gscl_pkg::CFG_OBSERV_STDEV, 18'h3_0100);
    write_reg(gscl_pkg::CFG_ERROR_MEAN, 18'h2_0000);
    write_reg(gscl_pkg::CFG_SCORE_THRESHOLD, 18'd196605);
    write_reg(CFG_UNMAPPED, 18'h3FFFF);     // must not disturb anything
    send_point(8'd2, 16'd0, 16'd0);          // max sum at max threshold: moving
    send_point(8'd3, 16'd5, 16'd0);
    drain_results();
    write_reg(gscl_pkg::CFG_SCORE_THRESHOLD, 18'h3FFFF);
    send_point(8'd2, 16'd0, 16'd0);
    drain_results();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'd196604);
    send_point(8'd255, 16'hFFFF, 16'hFFFF);
    send_point(8'd0, 16'd0, 16'd0);          // far in raw units, yet sd huge
    send_point(8'd255, 16'hFFFF, 16'hFFFE);
    drain_results();
  endtask

  // Random points near the configured means, with some fully random noise.
  task automatic test_random_points();
    logic [15:0] m [3];
    logic [15:0] s [3];
    logic [15:0] v [3];
    int unsigned spread;
    for (int k = 0; k < 8; k++) begin
      for (int f = 0; f < 3; f++) begin
        m[f] = 16'($urandom_range(65535));
        s[f] = (k == 7) ? 16'hFFFF : 16'($urandom_range(1 << $urandom_range(15)));
      end
      m[0][7:0] = (k % 2) ? 8'd0 : m[0][7:0];
      write_all(m[0], s[0], m[1], s[1], m[2], s[2],
                (k == 0) ? 18'd0 : (k == 1) ? 18'd196605 : 18'($urandom_range(196605)));
      case (k % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
        default: begin send_gap_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int j = 0; j < 190; j++) begin
        for (int f = 0; f < 3; f++) begin
          spread = 3 * s[f] + 1;
          if ($urandom_range(9) < 2) v[f] = 16'($urandom_range(65535));
          else if ($urandom_range(1)) v[f] = 16'(m[f] + $urandom_range(spread));
          else v[f] = 16'(m[f] - $urandom_range(spread));
        end
        send_point(v[0][15:8], v[1], v[2]);
      end
      drain_results();
    end
  endtask

  // Receiver side: random stalls per the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_static_q.size() == 0) begin
        $error("is_static: no item expected, actual %0d", out_ch.is_static);
        fail_count++;
      end else begin
        if (out_ch.is_static !== expected_static_q[0]) begin
          $error("is_static: expected %0d actual %0d", expected_static_q[0], out_ch.is_static);
          fail_count++;
        end
        void'(expected_static_q.pop_front());
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gaussian_score_point_classifier_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gscl_pkg::CFG_OBSERV_MEAN;
    cfg_wdata = 18'd0;
    in_ch.valid = 1'b0;
    in_ch.observ_count = 8'd0;
    in_ch.mean_error = 16'd0;
    in_ch.mean_depth = 16'd0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    for (int f = 0; f < 3; f++) begin
      feat_mean[f] = gscl_pkg::RST_MEAN;
      feat_sdev[f] = gscl_pkg::RST_STDEV;
    end
    static_thresh = gscl_pkg::RST_THRESHOLD;
    half_root_tap[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) half_root_tap[i] = floor_sqrt(half_root_tap[i-1] << 30);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_random_points();

    if (fail_count == 0) begin
      $display("gaussian_score_point_classifier_unit test passed");
    end else begin
      $display("gaussian_score_point_classifier_unit test failed");
    end
    $finish;
  end

endmodule
